FILE: hw/rtl/gds_pkg.sv
// Package of the Gregorian date stepper: request codes, controller states,
// the command and status structs and the calendar helper functions.
// No dependencies.
package gds_pkg;

    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int WDAY_W      = 3;
    localparam int REQ_W       = 3;
    localparam int DAY_COUNT_W = 16;

    localparam int DEF_COUNT_BITS = 16;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [YEAR_W-1:0]  RST_YEAR   = 14'd2017;
    localparam logic [MONTH_W-1:0] RST_MONTH  = 4'd12;
    localparam logic [DAY_W-1:0]   RST_DAY    = 5'd15;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD = 3'd0,
        REQ_NEXT = 3'd1,
        REQ_PREV = 3'd2,
        REQ_ADD  = 3'd3,
        REQ_SUB  = 3'd4
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PREP,
        S_STEP,
        S_WD1,
        S_WD2,
        S_WD3,
        S_WD4,
        S_OUT
    } t_state;

    typedef struct packed {
        logic cap;
        logic commit_load;
        logic start;
        logic step_fwd;
        logic step_bwd;
        logic commit_step;
        logic out_load;
        logic err;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic load_ok;
        logic over;
        logic under;
        logic fwd_fail;
        logic bwd_fail;
    } t_status;

    // Leap test without a divider: y/100 comes from a reciprocal multiply
    // that is exact for every 14-bit year.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [26:0] prod;
        logic [7:0]  cent;
        logic        cent_zero;
        prod      = 27'(y) * 27'(5243);
        cent      = prod[26:19];
        cent_zero = (y == 14'(16'(cent) * 16'd100));
        return ((y[1:0] == 2'b00) && !cent_zero) || (cent_zero && (cent[1:0] == 2'b00));
    endfunction

    // Days in a month; a month code outside 1..12 counts as 31.
    function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                    input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Month term (13*m + 8)/5 of the weekday sum, m from 3 to 14.
    function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
        logic [5:0] t;
        case (m)
            4'd3:    t = 6'd9;
            4'd4:    t = 6'd12;
            4'd5:    t = 6'd14;
            4'd6:    t = 6'd17;
            4'd7:    t = 6'd19;
            4'd8:    t = 6'd22;
            4'd9:    t = 6'd25;
            4'd10:   t = 6'd27;
            4'd11:   t = 6'd30;
            4'd12:   t = 6'd32;
            4'd13:   t = 6'd35;
            4'd14:   t = 6'd38;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

FILE: hw/rtl/gregorian_date_stepper_top.sv
// Top level of the Gregorian date stepper: stream ports, word packing and
// the controller and datapath instances. Depends on gds_pkg, gds_ctrl, gds_dpath.
//
// Usage: each request word on the slave channel loads a date, steps it by one
// day either way, or steps it by a signed day count; each request yields one
// result word on the master channel with the date, its weekday and an error
// flag (invalid load or a step outside years 1 to 9999; the date is held).
// The request code rides in s_axis_tuser, the error flag in m_axis_tuser.
// A load or an unused code goes from decode straight to the weekday states;
// a step first rolls the date over each month boundary it crosses, the
// month roll unit handling one month a cycle. A count of 32767 days rolls
// about 1080 months.
// One request is in flight at a time; s_axis_tready is high while the block
// waits for a request, even if the previous result is still waiting.
// A stalled receiver holds the result in the output register; the block
// then finishes the next request and waits until that register is taken.
// Reset sets the date to 2017-12-15 and empties the output register.
module gregorian_date_stepper_top import gds_pkg::*; #(
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // load_year[13:0], load_month[17:14], load_day[22:18], day_count[38:23], zero[39]
    input  logic [39:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cur_year[13:0], cur_month[17:14], cur_day[22:18], weekday[25:23], zero[31:26]
    output logic [31:0] m_axis_tdata,
    // error[0]
    output logic        m_axis_tuser
);

    t_cmd    cmd;
    t_status status;

    logic [YEAR_W-1:0]  cur_year;
    logic [MONTH_W-1:0] cur_month;
    logic [DAY_W-1:0]   cur_day;
    logic [WDAY_W-1:0]  weekday;
    logic               error;

    gds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    gds_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_req_type   (s_axis_tuser),
        .i_load_year  (s_axis_tdata[13:0]),
        .i_load_month (s_axis_tdata[17:14]),
        .i_load_day   (s_axis_tdata[22:18]),
        .i_day_count  (s_axis_tdata[38:23]),
        .o_cur_year   (cur_year),
        .o_cur_month  (cur_month),
        .o_cur_day    (cur_day),
        .o_weekday    (weekday),
        .o_error      (error)
    );

    assign m_axis_tdata = {6'd0, weekday, cur_day, cur_month, cur_year};
    assign m_axis_tuser = error;

endmodule

FILE: hw/rtl/gds_ctrl.sv
// Controller of the date stepper: request sequencing, error flag and the
// output word valid. Depends on gds_pkg.
module gds_ctrl import gds_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_err, n_err;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_err   = r_err;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.cap = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_err = 1'b0;
                unique case (i_status.req)
                    REQ_LOAD: begin
                        if (i_status.load_ok) begin
                            cmd.commit_load = 1'b1;
                        end else begin
                            n_err = 1'b1;
                        end
                        n_state = S_WD1;
                    end
                    REQ_NEXT, REQ_PREV, REQ_ADD, REQ_SUB: begin
                        cmd.start = 1'b1;
                        n_state   = S_PREP;
                    end
                    default: begin
                        n_state = S_WD1;
                    end
                endcase
            end
            // Lets the working leap flag catch up with the copied year before stepping.
            S_PREP: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                priority if (i_status.fwd_fail || i_status.bwd_fail) begin
                    n_err   = 1'b1;
                    n_state = S_WD1;
                end else if (i_status.over) begin
                    cmd.step_fwd = 1'b1;
                end else if (i_status.under) begin
                    cmd.step_bwd = 1'b1;
                end else begin
                    cmd.commit_step = 1'b1;
                    n_state         = S_WD1;
                end
            end
            S_WD1: n_state = S_WD2;
            S_WD2: n_state = S_WD3;
            S_WD3: n_state = S_WD4;
            S_WD4: n_state = S_OUT;
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.err      = r_err;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/gds_dpath.sv
// Datapath of the date stepper: captured request, committed and working
// date, month roll unit, weekday pipeline and output word. Depends on gds_pkg.
module gds_dpath import gds_pkg::*; #(
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic [REQ_W-1:0]       i_req_type,
    input  logic [YEAR_W-1:0]      i_load_year,
    input  logic [MONTH_W-1:0]     i_load_month,
    input  logic [DAY_W-1:0]       i_load_day,
    input  logic [DAY_COUNT_W-1:0] i_day_count,
    output logic [YEAR_W-1:0]      o_cur_year,
    output logic [MONTH_W-1:0]     o_cur_month,
    output logic [DAY_W-1:0]       o_cur_day,
    output logic [WDAY_W-1:0]      o_weekday,
    output logic                   o_error
);

    localparam int DW = COUNT_BITS + 1;

    // Captured request.
    t_req                   r_req;
    logic [YEAR_W-1:0]      r_ly;
    logic [MONTH_W-1:0]     r_lm;
    logic [DAY_W-1:0]       r_ld;
    logic [DAY_COUNT_W-1:0] r_cnt;

    // Committed date.
    logic [YEAR_W-1:0]  r_year;
    logic [MONTH_W-1:0] r_month;
    logic [DAY_W-1:0]   r_day;

    // Working date of a step in progress.
    logic [YEAR_W-1:0]    r_wy;
    logic [MONTH_W-1:0]   r_wm;
    logic signed [DW-1:0] r_wd;
    logic                 r_wleap;

    // Weekday pipeline.
    logic [YEAR_W-1:0] r_ya;
    logic [6:0]        r_mt;
    logic [7:0]        r_q100;
    logic [YEAR_W-1:0] r_sum;
    logic [11:0]       r_q7;

    // Output word.
    logic [YEAR_W-1:0]  r_o_year;
    logic [MONTH_W-1:0] r_o_month;
    logic [DAY_W-1:0]   r_o_day;
    logic [WDAY_W-1:0]  r_o_wday;
    logic               r_o_err;

    logic [COUNT_BITS+DAY_COUNT_W-1:0] cnt_ext;
    logic [COUNT_BITS-1:0]             cnt_low;
    logic signed [DW-1:0]              count;
    logic signed [DW-1:0]              step_n;
    logic signed [DW-1:0]              start_d;
    logic [DAY_W-1:0]                  mdays_cur;
    logic [DAY_W-1:0]                  mdays_prev;
    logic [MONTH_W-1:0]                prev_m;
    logic signed [DW-1:0]              mdays_cur_s;
    logic signed [DW-1:0]              mdays_prev_s;
    logic                              over;
    logic                              under;
    logic                              load_ok;
    logic                              early;
    logic [YEAR_W-1:0]                 ya;
    logic [MONTH_W-1:0]                ma;
    logic [26:0]                       prod100;
    logic [14:0]                       sum_w;
    logic [28:0]                       prod7;
    logic [WDAY_W-1:0]                 wday;

    // Only the low COUNT_BITS bits of the count field matter, sign-extended.
    assign cnt_ext = {{COUNT_BITS{1'b0}}, r_cnt};
    assign cnt_low = cnt_ext[COUNT_BITS-1:0];
    assign count   = signed'({cnt_low[COUNT_BITS-1], cnt_low});

    always_comb begin
        unique case (r_req)
            REQ_NEXT: step_n = signed'({{(DW-1){1'b0}}, 1'b1});
            REQ_PREV: step_n = signed'({DW{1'b1}});
            REQ_ADD:  step_n = count;
            REQ_SUB:  step_n = -count;
            default:  step_n = '0;
        endcase
    end

    assign start_d = signed'({{(DW-DAY_W){1'b0}}, r_day}) + step_n;

    assign mdays_cur    = month_days(r_wleap, r_wm);
    assign prev_m       = (r_wm == MONTH_JAN) ? MONTH_DEC : (r_wm - 4'd1);
    assign mdays_prev   = month_days(r_wleap, prev_m);
    assign mdays_cur_s  = signed'({{(DW-DAY_W){1'b0}}, mdays_cur});
    assign mdays_prev_s = signed'({{(DW-DAY_W){1'b0}}, mdays_prev});
    assign over         = (r_wd > mdays_cur_s);
    assign under        = r_wd[DW-1] || (r_wd == '0);

    assign load_ok = (r_ly >= YEAR_MIN) && (r_ly <= YEAR_MAX) &&
                     (r_lm >= MONTH_JAN) && (r_lm <= MONTH_DEC) &&
                     (r_ld != '0) && (r_ld <= month_days(is_leap(r_ly), r_lm));

    always_comb begin
        o_status          = '0;
        o_status.req      = r_req;
        o_status.load_ok  = load_ok;
        o_status.over     = over;
        o_status.under    = under;
        o_status.fwd_fail = over && (r_wm == MONTH_DEC) && (r_wy == YEAR_MAX);
        o_status.bwd_fail = under && (r_wm == MONTH_JAN) && (r_wy == YEAR_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req <= t_req'(i_req_type);
            r_ly  <= i_load_year;
            r_lm  <= i_load_month;
            r_ld  <= i_load_day;
            r_cnt <= i_day_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year  <= RST_YEAR;
            r_month <= RST_MONTH;
            r_day   <= RST_DAY;
        end else if (i_cmd.commit_load) begin
            r_year  <= r_ly;
            r_month <= r_lm;
            r_day   <= r_ld;
        end else if (i_cmd.commit_step) begin
            r_year  <= r_wy;
            r_month <= r_wm;
            r_day   <= r_wd[DAY_W-1:0];
        end
    end

    // One month per cycle. The leap flag is registered from the working year and
    // lags it, which is harmless: a year change always lands on January or December.
    always_ff @(posedge i_clk) begin
        r_wleap <= is_leap(r_wy);
        if (i_cmd.start) begin
            r_wy <= r_year;
            r_wm <= r_month;
            r_wd <= start_d;
        end else if (i_cmd.step_fwd) begin
            r_wd <= r_wd - mdays_cur_s;
            if (r_wm == MONTH_DEC) begin
                r_wm <= MONTH_JAN;
                r_wy <= r_wy + 14'd1;
            end else begin
                r_wm <= r_wm + 4'd1;
            end
        end else if (i_cmd.step_bwd) begin
            r_wm <= prev_m;
            r_wd <= r_wd + mdays_prev_s;
            if (r_wm == MONTH_JAN) begin
                r_wy <= r_wy - 14'd1;
            end
        end
    end

    // Weekday pipeline runs freely on the committed date, which stays put
    // while the controller walks through its four weekday states.
    assign early   = (r_month <= MONTH_FEB);
    assign ya      = early ? (r_year - 14'd1) : r_year;
    assign ma      = early ? (r_month + 4'd12) : r_month;
    assign prod100 = 27'(r_ya) * 27'(5243);
    assign sum_w   = 15'(r_ya) + 15'(r_ya >> 2) - 15'(r_q100) + 15'(r_q100 >> 2) +
                     15'(r_mt);
    assign prod7   = 29'(r_sum) * 29'(18725);
    assign wday    = 3'(r_sum - 14'(15'(r_q7) * 15'd7));

    always_ff @(posedge i_clk) begin
        r_ya   <= ya;
        r_mt   <= 7'(month_term(ma)) + 7'(r_day);
        r_q100 <= prod100[26:19];
        r_sum  <= sum_w[YEAR_W-1:0];
        r_q7   <= prod7[28:17];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_year  <= r_year;
            r_o_month <= r_month;
            r_o_day   <= r_day;
            r_o_wday  <= wday;
            r_o_err   <= i_cmd.err;
        end
    end

    assign o_cur_year  = r_o_year;
    assign o_cur_month = r_o_month;
    assign o_cur_day   = r_o_day;
    assign o_weekday   = r_o_wday;
    assign o_error     = r_o_err;

endmodule
